>>> sv/pps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power phase sequencer package
// Field widths, event and command codes, register indexes and the
// sequencer state record shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int VOLTAGE_W  = 8;
    localparam int CURRENT_W  = 16;
    localparam int COMMAND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Event codes carried in req_type
    localparam logic [REQ_TYPE_W-1:0] REQ_POLL      = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ARM       = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_DISABLE   = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_PHASE     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_NOT_READY = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_FETCH     = 3'd5;

    // Supply commands
    localparam logic [COMMAND_W-1:0] CMD_NONE = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_SET  = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_ON   = 2'd2;
    localparam logic [COMMAND_W-1:0] CMD_OFF  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT = 2'd1;

    localparam logic [VOLTAGE_W-1:0] MAX_VOLTAGE_RESET = 8'hFF;
    localparam logic [CURRENT_W-1:0] MAX_CURRENT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [VOLTAGE_W-1:0] pend_voltage;
        logic [CURRENT_W-1:0] pend_current;
        logic                 request_waiting;
        logic                 auto_flag;
        logic                 ready_flag;
        logic                 fault_flag;
        logic                 report_waiting;
        logic                 off_wanted;
        logic                 late_waiting;
        logic                 off_sent;
        logic [VOLTAGE_W-1:0] goal_voltage;
        logic [CURRENT_W-1:0] goal_current;
        logic                 goal_valid;
        logic                 setting_busy;
        logic [VOLTAGE_W-1:0] applied_voltage;
        logic [CURRENT_W-1:0] applied_current;
        logic                 applied_valid;
    } pps_state_t;

endpackage : pps_pkg
`default_nettype wire

>>> sv/pps_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power phase sequencer channel interfaces
// Event channel, result channel and configuration write channel, each
// with valid/ready handshake and source and sink modports.
// ----------------------------------------------------------------------------
interface pps_req_if
    import pps_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [VOLTAGE_W-1:0]  phase_voltage;
    logic [CURRENT_W-1:0]  phase_current;
    logic                  link_busy;
    logic                  link_error;
    logic                  link_has_config;
    logic                  link_output_on;
    logic                  link_accepts;

    modport source (
        output valid, req_type, phase_voltage, phase_current, link_busy,
               link_error, link_has_config, link_output_on, link_accepts,
        input  ready
    );
    modport sink (
        input  valid, req_type, phase_voltage, phase_current, link_busy,
               link_error, link_has_config, link_output_on, link_accepts,
        output ready
    );
endinterface : pps_req_if

interface pps_res_if
    import pps_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [COMMAND_W-1:0] command;
    logic [VOLTAGE_W-1:0] cmd_voltage;
    logic [CURRENT_W-1:0] cmd_current;
    logic                 ready_res;
    logic                 auto_on;
    logic                 fault_seen;

    modport source (
        output valid, command, cmd_voltage, cmd_current, ready_res, auto_on,
               fault_seen,
        input  ready
    );
    modport sink (
        input  valid, command, cmd_voltage, cmd_current, ready_res, auto_on,
               fault_seen,
        output ready
    );
endinterface : pps_res_if

interface pps_cfg_if
    import pps_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface : pps_cfg_if
`default_nettype wire

>>> sv/power_phase_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power phase sequencer core
// Steps a programmable supply through phases: takes one event item at a
// time with the link status bits and returns one command/status item.
// ----------------------------------------------------------------------------
// Usage:
//   req  - event items (poll, arm plan, disable, phase request, not ready,
//          fetch fault) with the supply link's status bits.
//   res  - exactly one result item per event: command, set-phase values
//          and the ready, automatic and fault-report status.
//   cfg  - register writes, index 0 maximum voltage, index 1 maximum current.
//          Always ready; write only while no items are in flight.
// From acceptance an item passes through the input register, then the
// sequencer step, which updates the state and the result register in the
// same edge. One item is accepted every cycle while res does not stall.
// When res stalls, the result register holds and one further item may wait
// in the input register; req.ready falls only when both are full.
// Reset clears all state to its power-up values (shutdown wanted) and sets
// the limits to their maximum.
// ----------------------------------------------------------------------------
module power_phase_sequencer_core
    import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pps_req_if.sink   req,
    pps_res_if.source res,
    pps_cfg_if.sink   cfg
);

    // Input register
    logic                  s1_valid_reg;
    logic [REQ_TYPE_W-1:0] s1_type_reg;
    logic [VOLTAGE_W-1:0]  s1_voltage_reg;
    logic [CURRENT_W-1:0]  s1_current_reg;
    logic                  s1_busy_reg;
    logic                  s1_err_reg;
    logic                  s1_cfg_reg;
    logic                  s1_on_reg;
    logic                  s1_acc_reg;

    logic [VOLTAGE_W-1:0] max_voltage_reg;
    logic [CURRENT_W-1:0] max_current_reg;

    pps_state_t state_reg, state_next;

    // Result register
    logic                 out_valid_reg;
    logic [COMMAND_W-1:0] out_command_reg, out_command_next;
    logic [VOLTAGE_W-1:0] out_voltage_reg, out_voltage_next;
    logic [CURRENT_W-1:0] out_current_reg, out_current_next;
    logic                 out_ready_res_reg, out_ready_res_next;
    logic                 out_auto_reg, out_auto_next;
    logic                 out_seen_reg, out_seen_next;

    logic advance;
    logic step;

    assign advance   = !out_valid_reg || res.ready;
    assign step      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    function automatic pps_state_t enter_fault(input pps_state_t s);
        pps_state_t r;
        r                 = s;
        r.auto_flag       = 1'b0;
        r.ready_flag      = 1'b0;
        r.request_waiting = 1'b0;
        r.goal_valid      = 1'b0;
        r.setting_busy    = 1'b0;
        r.applied_valid   = 1'b0;
        r.fault_flag      = 1'b1;
        r.report_waiting  = 1'b1;
        r.off_wanted      = 1'b1;
        return r;
    endfunction

    // One sequencer step on the registered event
    always_comb
    begin
        pps_state_t     st;
        logic [COMMAND_W-1:0] cmd;
        logic           seen;
        logic           go;
        st   = state_reg;
        cmd  = CMD_NONE;
        seen = 1'b0;
        go   = 1'b0;
        case (s1_type_reg)
            REQ_POLL:
            begin
                if (st.late_waiting)
                begin
                    st.late_waiting = 1'b0;
                    st = enter_fault(st);
                end
                if (st.off_wanted)
                begin
                    if (!s1_busy_reg)
                    begin
                        if (!st.off_sent)
                        begin
                            // A refused shutdown is reported and retried later.
                            if (!s1_acc_reg)
                            begin
                                st.fault_flag     = 1'b1;
                                st.report_waiting = 1'b1;
                            end
                            else
                            begin
                                st.off_sent = 1'b1;
                                cmd         = CMD_OFF;
                            end
                        end
                        else
                        begin
                            st.off_sent      = 1'b0;
                            st.off_wanted    = 1'b0;
                            st.ready_flag    = 1'b0;
                            st.goal_valid    = 1'b0;
                            st.setting_busy  = 1'b0;
                            st.applied_valid = 1'b0;
                        end
                    end
                end
                else if (st.auto_flag && !st.fault_flag)
                begin
                    go = 1'b1;
                    if (st.setting_busy)
                    begin
                        if (s1_busy_reg)
                        begin
                            go = 1'b0;
                        end
                        else if (s1_err_reg || !s1_cfg_reg)
                        begin
                            st = enter_fault(st);
                            go = 1'b0;
                        end
                        else
                        begin
                            st.applied_voltage = st.goal_voltage;
                            st.applied_current = st.goal_current;
                            st.applied_valid   = 1'b1;
                            st.setting_busy    = 1'b0;
                        end
                    end
                    if (go && st.request_waiting)
                    begin
                        if (s1_busy_reg)
                        begin
                            go = 1'b0;
                        end
                        else
                        begin
                            st.goal_voltage    = st.pend_voltage;
                            st.goal_current    = st.pend_current;
                            st.request_waiting = 1'b0;
                            st.goal_valid      = 1'b1;
                            // The same setting already applied needs no command.
                            if (st.applied_valid &&
                                st.applied_voltage == st.goal_voltage &&
                                st.applied_current == st.goal_current &&
                                s1_cfg_reg && !s1_err_reg)
                            begin
                                st.setting_busy = 1'b0;
                            end
                            else
                            begin
                                go = 1'b0;
                                if (!s1_acc_reg)
                                begin
                                    st = enter_fault(st);
                                end
                                else
                                begin
                                    st.setting_busy = 1'b1;
                                    cmd             = CMD_SET;
                                end
                            end
                        end
                    end
                    if (go && st.goal_valid && !s1_busy_reg)
                    begin
                        if (s1_err_reg || !s1_cfg_reg)
                        begin
                            st = enter_fault(st);
                        end
                        else if (!s1_on_reg)
                        begin
                            if (!s1_acc_reg)
                            begin
                                st = enter_fault(st);
                            end
                            else
                            begin
                                cmd = CMD_ON;
                            end
                        end
                        else
                        begin
                            st.ready_flag = 1'b1;
                        end
                    end
                end
            end
            REQ_ARM:
            begin
                st.auto_flag       = 1'b1;
                st.ready_flag      = 1'b0;
                st.request_waiting = 1'b0;
                st.late_waiting    = 1'b0;
                st.goal_valid      = 1'b0;
                st.setting_busy    = 1'b0;
                st.applied_valid   = 1'b0;
                st.fault_flag      = 1'b0;
                st.report_waiting  = 1'b0;
            end
            REQ_DISABLE:
            begin
                st.auto_flag       = 1'b0;
                st.ready_flag      = 1'b0;
                st.request_waiting = 1'b0;
                st.late_waiting    = 1'b0;
                st.off_wanted      = 1'b1;
            end
            REQ_PHASE:
            begin
                if (st.auto_flag && !st.fault_flag)
                begin
                    // An out-of-limit request faults at the next poll.
                    if (s1_voltage_reg > max_voltage_reg ||
                        s1_current_reg > max_current_reg)
                    begin
                        st.auto_flag       = 1'b0;
                        st.ready_flag      = 1'b0;
                        st.request_waiting = 1'b0;
                        st.late_waiting    = 1'b1;
                    end
                    else
                    begin
                        st.ready_flag      = 1'b0;
                        st.pend_voltage    = s1_voltage_reg;
                        st.pend_current    = s1_current_reg;
                        st.request_waiting = 1'b1;
                    end
                end
            end
            REQ_NOT_READY:
            begin
                if (!st.ready_flag)
                begin
                    st.late_waiting = 1'b1;
                end
            end
            REQ_FETCH:
            begin
                seen              = st.report_waiting;
                st.report_waiting = 1'b0;
            end
            default:
            begin
            end
        endcase

        state_next         = st;
        out_command_next   = cmd;
        out_voltage_next   = (cmd == CMD_SET) ? st.goal_voltage : '0;
        out_current_next   = (cmd == CMD_SET) ? st.goal_current : '0;
        out_ready_res_next = st.auto_flag && !st.fault_flag && st.ready_flag;
        out_auto_next      = st.auto_flag;
        out_seen_next      = seen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_voltage_reg <= MAX_VOLTAGE_RESET;
            max_current_reg <= MAX_CURRENT_RESET;
            state_reg       <= '{off_wanted: 1'b1, default: '0};
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_MAX_VOLTAGE)
                begin
                    max_voltage_reg <= cfg.data[VOLTAGE_W-1:0];
                end
                else if (cfg.index == REG_MAX_CURRENT)
                begin
                    max_current_reg <= cfg.data[CURRENT_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg    <= req.req_type;
            s1_voltage_reg <= req.phase_voltage;
            s1_current_reg <= req.phase_current;
            s1_busy_reg    <= req.link_busy;
            s1_err_reg     <= req.link_error;
            s1_cfg_reg     <= req.link_has_config;
            s1_on_reg      <= req.link_output_on;
            s1_acc_reg     <= req.link_accepts;
        end
        if (step)
        begin
            out_command_reg   <= out_command_next;
            out_voltage_reg   <= out_voltage_next;
            out_current_reg   <= out_current_next;
            out_ready_res_reg <= out_ready_res_next;
            out_auto_reg      <= out_auto_next;
            out_seen_reg      <= out_seen_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.command     = out_command_reg;
    assign res.cmd_voltage = out_voltage_reg;
    assign res.cmd_current = out_current_reg;
    assign res.ready_res   = out_ready_res_reg;
    assign res.auto_on     = out_auto_reg;
    assign res.fault_seen  = out_seen_reg;

`ifndef SYNTHESIS
    // Only a full pipeline with a stalled receiver may refuse an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !res.ready))
    else $error("event channel stalled without a full pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.command != CMD_SET) |->
        (res.cmd_voltage == '0 && res.cmd_current == '0))
    else $error("phase values shown without a set-phase command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready_res) |-> res.auto_on)
    else $error("ready reported outside automatic mode");

    // A stepped item always leaves a result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
    else $error("stepped item left no result");
`endif

endmodule : power_phase_sequencer_core
`default_nettype wire

>>> tb/sv/power_phase_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Power phase sequencer core testbench
// Drives event items with link status bits through the request channel and
// checks every result item against an in-bench model of the sequencer or, for
// checked directed rows, a written reply. A short table of directed items
// comes first, then random episodes under several voltage and current limit
// settings, with bursty sending and receiver stalls.
// ----------------------------------------------------------------------------
module power_phase_sequencer_core_tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int SETTING_COUNT      = 7;
    localparam int RANDOM_PER_SETTING = 257;

    // Event codes the block must ignore.
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

    // Link status as {busy, error, has_config, output_on, accepts}.
    typedef logic [4:0] link_bits_t;
    localparam link_bits_t LINK_IDLE_OFF = 5'b00101;
    localparam link_bits_t LINK_IDLE_ON  = 5'b00111;
    localparam link_bits_t LINK_BUSY     = 5'b10101;
    localparam link_bits_t LINK_REFUSE   = 5'b00100;
    localparam link_bits_t LINK_ERROR    = 5'b01101;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] code;
        logic [VOLTAGE_W-1:0]  volt;
        logic [CURRENT_W-1:0]  curr;
        logic                  busy;
        logic                  err;
        logic                  has_cfg;
        logic                  out_on;
        logic                  accepts;
    } seq_item_t;

    typedef struct packed {
        logic [COMMAND_W-1:0] command;
        logic [VOLTAGE_W-1:0] volt;
        logic [CURRENT_W-1:0] curr;
        logic                 ready_res;
        logic                 auto_on;
        logic                 fault_seen;
    } seq_reply_t;

    localparam seq_reply_t NO_REPLY = '0;

    typedef struct packed {
        logic [VOLTAGE_W-1:0] pend_v;
        logic [CURRENT_W-1:0] pend_c;
        logic                 req_wait;
        logic                 auto_on;
        logic                 ready;
        logic                 fault;
        logic                 report;
        logic                 off_want;
        logic                 late;
        logic                 off_sent;
        logic [VOLTAGE_W-1:0] goal_v;
        logic [CURRENT_W-1:0] goal_c;
        logic                 goal_ok;
        logic                 setting;
        logic [VOLTAGE_W-1:0] applied_v;
        logic [CURRENT_W-1:0] applied_c;
        logic                 applied_ok;
    } seq_state_t;

    typedef struct {
        bit                    is_cfg;
        seq_item_t             item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    checked;
        seq_reply_t            want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    pps_req_if req_ch ();
    pps_res_if res_ch ();
    pps_cfg_if cfg_ch ();

    power_phase_sequencer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    seq_state_t           sq;
    logic [VOLTAGE_W-1:0] lim_v;
    logic [CURRENT_W-1:0] lim_c;
    seq_reply_t           awaited_status[$];
    plan_row_t            plan_rows[$];
    int                   mismatch_count;
    int                   items_sent;
    int                   burst_left;
    int                   cycle_count;
    int                   stall_mode;
    int                   stall_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic void trip_fault();
        sq.auto_on    = 1'b0;
        sq.ready      = 1'b0;
        sq.req_wait   = 1'b0;
        sq.goal_ok    = 1'b0;
        sq.setting    = 1'b0;
        sq.applied_ok = 1'b0;
        sq.fault      = 1'b1;
        sq.report     = 1'b1;
        sq.off_want   = 1'b1;
    endfunction

    function automatic logic [COMMAND_W-1:0] poll_supply(input seq_item_t it);
        if (sq.late) begin
            sq.late = 1'b0;
            trip_fault();
        end
        if (sq.off_want) begin
            if (it.busy)
                return CMD_NONE;
            if (!sq.off_sent) begin
                // A refused shutdown stays wanted and is retried next poll.
                if (!it.accepts) begin
                    sq.fault  = 1'b1;
                    sq.report = 1'b1;
                    return CMD_NONE;
                end
                sq.off_sent = 1'b1;
                return CMD_OFF;
            end
            sq.off_sent   = 1'b0;
            sq.off_want   = 1'b0;
            sq.ready      = 1'b0;
            sq.goal_ok    = 1'b0;
            sq.setting    = 1'b0;
            sq.applied_ok = 1'b0;
            return CMD_NONE;
        end
        if (!sq.auto_on || sq.fault)
            return CMD_NONE;
        if (sq.setting) begin
            if (it.busy)
                return CMD_NONE;
            if (it.err || !it.has_cfg) begin
                trip_fault();
                return CMD_NONE;
            end
            sq.applied_v  = sq.goal_v;
            sq.applied_c  = sq.goal_c;
            sq.applied_ok = 1'b1;
            sq.setting    = 1'b0;
        end
        if (sq.req_wait) begin
            if (it.busy)
                return CMD_NONE;
            sq.goal_v   = sq.pend_v;
            sq.goal_c   = sq.pend_c;
            sq.req_wait = 1'b0;
            sq.goal_ok  = 1'b1;
            // The same voltage and current as already applied need no command.
            if (sq.applied_ok && sq.applied_v == sq.goal_v && sq.applied_c == sq.goal_c
                && it.has_cfg && !it.err) begin
                sq.setting = 1'b0;
            end
            else begin
                if (!it.accepts) begin
                    trip_fault();
                    return CMD_NONE;
                end
                sq.setting = 1'b1;
                return CMD_SET;
            end
        end
        if (!sq.goal_ok || it.busy)
            return CMD_NONE;
        if (it.err || !it.has_cfg) begin
            trip_fault();
            return CMD_NONE;
        end
        if (!it.out_on) begin
            if (!it.accepts) begin
                trip_fault();
                return CMD_NONE;
            end
            return CMD_ON;
        end
        sq.ready = 1'b1;
        return CMD_NONE;
    endfunction

    function automatic seq_reply_t advance_sequencer(input seq_item_t it);
        seq_reply_t r;
        r = NO_REPLY;
        case (it.code)
            REQ_POLL: r.command = poll_supply(it);
            REQ_ARM:
            begin
                sq.auto_on    = 1'b1;
                sq.ready      = 1'b0;
                sq.req_wait   = 1'b0;
                sq.late       = 1'b0;
                sq.goal_ok    = 1'b0;
                sq.setting    = 1'b0;
                sq.applied_ok = 1'b0;
                sq.fault      = 1'b0;
                sq.report     = 1'b0;
            end
            REQ_DISABLE:
            begin
                sq.auto_on  = 1'b0;
                sq.ready    = 1'b0;
                sq.req_wait = 1'b0;
                sq.late     = 1'b0;
                sq.off_want = 1'b1;
            end
            REQ_PHASE:
            begin
                if (sq.auto_on && !sq.fault) begin
                    if (it.volt > lim_v || it.curr > lim_c) begin
                        sq.auto_on  = 1'b0;
                        sq.ready    = 1'b0;
                        sq.req_wait = 1'b0;
                        sq.late     = 1'b1;
                    end
                    else begin
                        sq.ready    = 1'b0;
                        sq.pend_v   = it.volt;
                        sq.pend_c   = it.curr;
                        sq.req_wait = 1'b1;
                    end
                end
            end
            REQ_NOT_READY:
            begin
                if (!sq.ready)
                    sq.late = 1'b1;
            end
            REQ_FETCH:
            begin
                r.fault_seen = sq.report;
                sq.report    = 1'b0;
            end
            default: ;
        endcase
        if (r.command == CMD_SET) begin
            r.volt = sq.goal_v;
            r.curr = sq.goal_c;
        end
        r.ready_res = sq.auto_on && !sq.fault && sq.ready;
        r.auto_on   = sq.auto_on;
        return r;
    endfunction

    function automatic void apply_limit(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_MAX_VOLTAGE)
            lim_v = data[VOLTAGE_W-1:0];
        else if (idx == REG_MAX_CURRENT)
            lim_c = data[CURRENT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------------
    function automatic seq_reply_t make_reply(input logic [COMMAND_W-1:0] cmd,
                                              input logic [VOLTAGE_W-1:0] v,
                                              input logic [CURRENT_W-1:0] c,
                                              input logic rdy, input logic aut,
                                              input logic seen);
        seq_reply_t r;
        r.command    = cmd;
        r.volt       = v;
        r.curr       = c;
        r.ready_res  = rdy;
        r.auto_on    = aut;
        r.fault_seen = seen;
        return r;
    endfunction

    task automatic put_row(input logic [REQ_TYPE_W-1:0] code, input logic [VOLTAGE_W-1:0] v,
                           input logic [CURRENT_W-1:0] c, input link_bits_t link,
                           input bit checked, input seq_reply_t want);
        plan_row_t row;
        row.is_cfg    = 1'b0;
        row.item.code = code;
        row.item.volt = v;
        row.item.curr = c;
        {row.item.busy, row.item.err, row.item.has_cfg, row.item.out_on,
         row.item.accepts} = link;
        row.reg_idx   = REG_MAX_VOLTAGE;
        row.reg_data  = '0;
        row.checked   = checked;
        row.want      = want;
        plan_rows.push_back(row);
    endtask

    task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.is_cfg   = 1'b1;
        row.item     = '0;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.checked  = 1'b0;
        row.want     = NO_REPLY;
        plan_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input seq_item_t it, input bit typed, input seq_reply_t typed_reply);
        seq_reply_t predicted;
        int         gap;
        if (cfg_ch.valid)
            cfg_ch.valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= it.code;
        req_ch.phase_voltage   <= it.volt;
        req_ch.phase_current   <= it.curr;
        req_ch.link_busy       <= it.busy;
        req_ch.link_error      <= it.err;
        req_ch.link_has_config <= it.has_cfg;
        req_ch.link_output_on  <= it.out_on;
        req_ch.link_accepts    <= it.accepts;
        do @(posedge clk); while (!req_ch.ready);
        predicted = advance_sequencer(it);
        awaited_status.push_back(typed ? typed_reply : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Limits change only once every outstanding result has come back.
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        burst_left = 0;
        while (awaited_status.size() != 0)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_limit(idx, data);
        @(negedge clk);
    endtask

    function automatic seq_item_t noise_item();
        seq_item_t it;
        it.code    = REQ_TYPE_W'($urandom_range(0, 7));
        it.volt    = VOLTAGE_W'($urandom);
        it.curr    = CURRENT_W'($urandom);
        it.busy    = 1'($urandom_range(0, 1));
        it.err     = 1'($urandom_range(0, 1));
        it.has_cfg = 1'($urandom_range(0, 1));
        it.out_on  = 1'($urandom_range(0, 1));
        it.accepts = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // A poll with a mostly healthy link, so that plans run through to ready.
    function automatic seq_item_t healthy_poll();
        seq_item_t it;
        it         = noise_item();
        it.code    = REQ_POLL;
        it.busy    = ($urandom_range(0, 9) == 0);
        it.err     = ($urandom_range(0, 49) == 0);
        it.has_cfg = ($urandom_range(0, 32) != 0);
        it.accepts = ($urandom_range(0, 19) != 0);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        seq_reply_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_status.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual command %0h",
                         $time, res_ch.command);
                mismatch_count++;
            end
            else begin
                want = awaited_status.pop_front();
                report_field("command", 16'(want.command), 16'(res_ch.command));
                report_field("cmd_voltage", 16'(want.volt), 16'(res_ch.cmd_voltage));
                report_field("cmd_current", want.curr, res_ch.cmd_current);
                report_field("ready_res", 16'(want.ready_res), 16'(res_ch.ready_res));
                report_field("auto_on", 16'(want.auto_on), 16'(res_ch.auto_on));
                report_field("fault_seen", 16'(want.fault_seen), 16'(res_ch.fault_seen));
            end
        end
    end

    // Receiver back-pressure: windows of free flow, light and heavy random
    // stalls, and a periodic pattern.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end
        stall_left--;
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (stall_left % 3 != 0);
        endcase
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("power_phase_sequencer_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        seq_item_t            it;
        logic [VOLTAGE_W-1:0] lv;
        logic [CURRENT_W-1:0] lc;
        logic [VOLTAGE_W-1:0] last_v;
        logic [CURRENT_W-1:0] last_c;
        int                   start;
        int                   pick;

        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_POLL;
        req_ch.phase_voltage   = '0;
        req_ch.phase_current   = '0;
        req_ch.link_busy       = 1'b0;
        req_ch.link_error      = 1'b0;
        req_ch.link_has_config = 1'b0;
        req_ch.link_output_on  = 1'b0;
        req_ch.link_accepts    = 1'b0;
        res_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_MAX_VOLTAGE;
        cfg_ch.data            = '0;
        mismatch_count         = 0;
        items_sent             = 0;
        burst_left             = 0;
        cycle_count            = 0;
        stall_mode             = 0;
        stall_left             = 0;
        last_v                 = '0;
        last_c                 = '0;

        sq          = '0;
        sq.off_want = 1'b1;
        lim_v       = MAX_VOLTAGE_RESET;
        lim_c       = MAX_CURRENT_RESET;

        // Out of reset a shutdown is wanted, so the first polls switch off.
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_OFF, 0, 0, 0, 0, 0));
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 0, NO_REPLY);
        put_row(REQ_ARM, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_NONE, 0, 0, 0, 1, 0));
        put_row(REQ_PHASE, 8'hFF, 16'hFFFF, LINK_IDLE_OFF, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 1,
                make_reply(CMD_SET, 8'hFF, 16'hFFFF, 0, 1, 0));
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_ON, 0, 0, 0, 1, 0));
        put_row(REQ_POLL, 0, 0, LINK_IDLE_ON, 1, make_reply(CMD_NONE, 0, 0, 1, 1, 0));
        put_row(REQ_NOT_READY, 0, 0, LINK_IDLE_ON, 0, NO_REPLY);
        // Repeating the applied phase must not issue a second set phase.
        put_row(REQ_PHASE, 8'hFF, 16'hFFFF, LINK_IDLE_ON, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_IDLE_ON, 0, NO_REPLY);
        put_row(REQ_SPARE_6, 8'hA5, 16'h5A5A, LINK_IDLE_ON, 0, NO_REPLY);
        put_row(REQ_SPARE_7, 8'h5A, 16'hA5A5, LINK_IDLE_ON, 0, NO_REPLY);
        put_row(REQ_PHASE, 0, 0, LINK_IDLE_ON, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_REFUSE, 1, make_reply(CMD_NONE, 0, 0, 0, 0, 0));
        put_row(REQ_FETCH, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_NONE, 0, 0, 0, 0, 1));
        put_row(REQ_FETCH, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_NONE, 0, 0, 0, 0, 0));
        put_row(REQ_PHASE, 8'd9, 16'd9, LINK_IDLE_OFF, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_BUSY, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_REFUSE, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_OFF, 0, 0, 0, 0, 0));
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 0, NO_REPLY);
        // Upper data bits of the voltage limit are not part of the register.
        put_cfg(REG_MAX_VOLTAGE, 16'hAB64);
        put_cfg(REG_MAX_CURRENT, 16'd1000);
        put_row(REQ_ARM, 0, 0, LINK_IDLE_OFF, 0, NO_REPLY);
        put_row(REQ_PHASE, 8'd101, 16'd1000, LINK_IDLE_OFF, 1,
                make_reply(CMD_NONE, 0, 0, 0, 0, 0));
        put_row(REQ_POLL, 0, 0, LINK_IDLE_OFF, 1, make_reply(CMD_OFF, 0, 0, 0, 0, 0));
        put_row(REQ_DISABLE, 0, 0, LINK_IDLE_OFF, 0, NO_REPLY);
        put_row(REQ_POLL, 0, 0, LINK_ERROR, 0, NO_REPLY);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].is_cfg)
                write_limit(plan_rows[i].reg_idx, plan_rows[i].reg_data);
            else
                send_item(plan_rows[i].item, plan_rows[i].checked, plan_rows[i].want);
        end

        for (int p = 0; p < SETTING_COUNT; p++) begin
            case (p)
                0: begin lv = 8'hFF; lc = 16'hFFFF; end
                1: begin lv = 8'h00; lc = 16'h0000; end
                2: begin lv = 8'd100; lc = 16'd1000; end
                3: begin lv = 8'hFF; lc = 16'h0000; end
                4: begin lv = 8'h00; lc = 16'hFFFF; end
                default:
                begin
                    lv = VOLTAGE_W'($urandom);
                    lc = CURRENT_W'($urandom);
                end
            endcase
            write_limit(REG_MAX_VOLTAGE, {8'($urandom), lv});
            write_limit(REG_MAX_CURRENT, lc);

            start = items_sent;
            while (items_sent - start < RANDOM_PER_SETTING) begin
                if ($urandom_range(0, 9) < 7) begin
                    // A plan: finish any shutdown, arm, then phases, polls, not-ready and fetch items.
                    if ($urandom_range(0, 3) == 0) begin
                        it      = noise_item();
                        it.code = REQ_DISABLE;
                        send_item(it, 0, NO_REPLY);
                    end
                    repeat (2) begin
                        it         = healthy_poll();
                        it.busy    = 1'b0;
                        it.accepts = 1'b1;
                        send_item(it, 0, NO_REPLY);
                    end
                    it      = noise_item();
                    it.code = REQ_ARM;
                    send_item(it, 0, NO_REPLY);
                    repeat ($urandom_range(3, 12)) begin
                        pick = $urandom_range(0, 99);
                        it   = noise_item();
                        if (pick < 20) begin
                            it.code = REQ_PHASE;
                            if ($urandom_range(0, 3) == 0) begin
                                it.volt = last_v;
                                it.curr = last_c;
                            end
                            else if ($urandom_range(0, 9) != 0) begin
                                it.volt = VOLTAGE_W'($urandom_range(0, lim_v));
                                it.curr = CURRENT_W'($urandom_range(0, lim_c));
                            end
                            last_v = it.volt;
                            last_c = it.curr;
                        end
                        else if (pick < 25)
                            it.code = REQ_NOT_READY;
                        else if (pick < 30)
                            it.code = REQ_FETCH;
                        else
                            it = healthy_poll();
                        send_item(it, 0, NO_REPLY);
                    end
                end
                else begin
                    repeat ($urandom_range(2, 8))
                        send_item(noise_item(), 0, NO_REPLY);
                end
            end
        end

        if (cfg_ch.valid)
            cfg_ch.valid <= 1'b0;
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("power_phase_sequencer_core_tb: PASS");
        else
            $display("power_phase_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule : power_phase_sequencer_core_tb

>>> filelist.f
sv/pps_pkg.sv
sv/pps_if.sv
sv/power_phase_sequencer_core.sv
tb/sv/power_phase_sequencer_core_tb.sv
